@@ hdl/sisc_pkg.sv @@
`default_nettype none
package sisc_pkg;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_W = 3;
    localparam int COIL_W = 4;
    localparam int TABLE_W = 32;
    localparam int CNT_W = 32;
    localparam int REV_W = 16;
    localparam int LIMIT_W = REV_W + 1;
    localparam int STEP_W = 21;
    localparam int REVS_PER_CAL = 3;
    localparam int MID_DIV = 2 * REVS_PER_CAL;
    localparam int RUN_DIV_SHIFT = 3;
    localparam int RUN_FULL_DOSE = 8;

    localparam logic [TABLE_W-1:0] PHASE_TABLE_RESET = 32'h98C4_6231;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_CAL = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SEEK = 3'd1;
    localparam logic [2:0] MODE_INSIDE = 3'd2;
    localparam logic [2:0] MODE_OUTSIDE = 3'd3;
    localparam logic [2:0] MODE_CENTER = 3'd4;
    localparam logic [2:0] MODE_RUN = 3'd5;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy_res;
        logic              calibrated;
        logic [REV_W-1:0]  rev_half_steps;
    } sisc_result_t;

endpackage
`default_nettype wire

@@ hdl/sisc_if.sv @@
`default_nettype none
interface sisc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       sensor_level;
    logic [7:0] dose_eighths;

    modport source (output valid, output kind, output sensor_level, output dose_eighths,
                    input ready);
    modport sink (input valid, input kind, input sensor_level, input dose_eighths,
                  output ready);
endinterface

interface sisc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  coils;
    logic        busy_res;
    logic        calibrated;
    logic [15:0] rev_half_steps;

    modport source (output valid, output coils, output busy_res, output calibrated,
                    output rev_half_steps, input ready);
    modport sink (input valid, input coils, input busy_res, input calibrated,
                  input rev_half_steps, output ready);
endinterface
`default_nettype wire

@@ hdl/stepper_index_calibration_sequencer.sv @@
// Half-step stepper sequencer with index-sensor homing. Every accepted item
// (tick, calibrate or run command) gives exactly one result: the coil pattern,
// busy flag, calibrated flag and measured steps per revolution after that item.
// One item is taken per clock unless the buffer is full; its result is ready in
// the output buffer on the next cycle. The two-entry output buffer sets the
// stall behavior: input is taken while at most one result waits, so a blocked
// output stops the input after two items. Steps-per-revolution and the
// centering offset are kept as running quotients while counting. No clearing
// pass follows reset. Write phase_table only while idle.
`default_nettype none
module stepper_index_calibration_sequencer
    import sisc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    sisc_in_if.sink                 in_ch,
    sisc_out_if.source              out_ch,
    input  wire logic               phase_table_we,
    input  wire logic [TABLE_W-1:0] phase_table_wdata
);

    logic         acc;
    logic         can_push;
    sisc_result_t res;

    assign in_ch.ready = can_push;
    assign acc         = in_ch.valid && can_push;

    sisc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .kind         (in_ch.kind),
        .sensor_level (in_ch.sensor_level),
        .dose_eighths (in_ch.dose_eighths),
        .cfg_we       (phase_table_we),
        .cfg_wdata    (phase_table_wdata),
        .res          (res)
    );

    sisc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc),
        .push_data (res),
        .can_push  (can_push),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

@@ hdl/sisc_core.sv @@
`default_nettype none
module sisc_core
    import sisc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               acc,
    input  wire logic [1:0]         kind,
    input  wire logic               sensor_level,
    input  wire logic [7:0]         dose_eighths,
    input  wire logic               cfg_we,
    input  wire logic [TABLE_W-1:0] cfg_wdata,
    output sisc_result_t            res
);

    logic [TABLE_W-1:0] table_reg;
    logic [2:0]         mode_reg, mode_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               last_sensor_reg, last_sensor_next;
    logic [1:0]         rev_count_reg, rev_count_next;
    logic [CNT_W-1:0]   inside_reg, inside_next;
    logic [2:0]         inside_rem_reg, inside_rem_next;
    logic [REV_W-1:0]   inside_q_reg, inside_q_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [1:0]         total_rem_reg, total_rem_next;
    logic [REV_W-1:0]   total_q_reg, total_q_next;
    logic [REV_W-1:0]   rev_steps_reg, rev_steps_next;
    logic [REV_W-1:0]   mid_reg, mid_next;
    logic               cal_reg, cal_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COIL_W-1:0]  coil_reg, coil_next;

    logic               at_boundary;
    logic [COIL_W-1:0]  coil_step;
    logic [PHASE_W:0]   phase_inc;
    logic [PHASE_W-1:0] phase_step;
    logic               ins_wrap, tot_wrap;
    logic [CNT_W-1:0]   ins_cnt_inc, tot_cnt_inc;
    logic [2:0]         ins_rem_inc;
    logic [1:0]         tot_rem_inc;
    logic [REV_W-1:0]   ins_q_inc, tot_q_inc;
    logic [LIMIT_W-1:0] center_limit;
    logic [STEP_W-1:0]  step_inc;
    logic [STEP_W-1:0]  run_steps;
    logic [1:0]         rev_count_inc;

    assign at_boundary = (phase_reg == '0);
    assign coil_step   = table_reg[{phase_reg, 2'b00} +: COIL_W];
    assign phase_inc   = {1'b0, phase_reg} + (PHASE_W+1)'(1);
    assign phase_step  = (phase_inc >= (PHASE_W+1)'(PHASE_COUNT)) ? '0 : phase_inc[PHASE_W-1:0];

    // running quotients so the divides are ready when counting ends
    assign ins_wrap    = &inside_reg;
    assign ins_cnt_inc = inside_reg + CNT_W'(1);
    always_comb
    begin
        if (ins_wrap)
        begin
            ins_rem_inc = '0;
            ins_q_inc   = '0;
        end
        else if (inside_rem_reg == 3'(MID_DIV - 1))
        begin
            ins_rem_inc = '0;
            ins_q_inc   = inside_q_reg + REV_W'(1);
        end
        else
        begin
            ins_rem_inc = inside_rem_reg + 3'd1;
            ins_q_inc   = inside_q_reg;
        end
    end

    assign tot_wrap    = &total_reg;
    assign tot_cnt_inc = total_reg + CNT_W'(1);
    always_comb
    begin
        if (tot_wrap)
        begin
            tot_rem_inc = '0;
            tot_q_inc   = '0;
        end
        else if (total_rem_reg == 2'(REVS_PER_CAL - 1))
        begin
            tot_rem_inc = '0;
            tot_q_inc   = total_q_reg + REV_W'(1);
        end
        else
        begin
            tot_rem_inc = total_rem_reg + 2'd1;
            tot_q_inc   = total_q_reg;
        end
    end

    assign center_limit  = LIMIT_W'(rev_steps_reg) + LIMIT_W'(mid_reg);
    assign step_inc      = step_reg + STEP_W'(1);
    assign rev_count_inc = rev_count_reg + 2'd1;
    assign run_steps     = ((dose_eighths == '0) || (dose_eighths == 8'(RUN_FULL_DOSE)))
                         ? STEP_W'(rev_steps_reg)
                         : STEP_W'(rev_steps_reg[REV_W-1:RUN_DIV_SHIFT]) * STEP_W'(dose_eighths);

    always_comb
    begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        last_sensor_next = last_sensor_reg;
        rev_count_next   = rev_count_reg;
        inside_next      = inside_reg;
        inside_rem_next  = inside_rem_reg;
        inside_q_next    = inside_q_reg;
        total_next       = total_reg;
        total_rem_next   = total_rem_reg;
        total_q_next     = total_q_reg;
        rev_steps_next   = rev_steps_reg;
        mid_next         = mid_reg;
        cal_next         = cal_reg;
        step_next        = step_reg;
        coil_next        = coil_reg;

        if (kind == KIND_TICK)
        begin
            case (mode_reg)
                MODE_SEEK:
                begin
                    if (at_boundary && !sensor_level && last_sensor_reg)
                    begin
                        coil_next = '0;
                        mode_next = MODE_INSIDE;
                    end
                    else
                    begin
                        if (at_boundary)
                        begin
                            last_sensor_next = sensor_level;
                        end
                        coil_next  = coil_step;
                        phase_next = phase_step;
                    end
                end
                MODE_INSIDE:
                begin
                    coil_next      = coil_step;
                    phase_next     = phase_step;
                    total_next     = tot_cnt_inc;
                    total_rem_next = tot_rem_inc;
                    total_q_next   = tot_q_inc;
                    if (at_boundary && sensor_level)
                    begin
                        mode_next = MODE_OUTSIDE;
                    end
                    else
                    begin
                        inside_next     = ins_cnt_inc;
                        inside_rem_next = ins_rem_inc;
                        inside_q_next   = ins_q_inc;
                    end
                end
                MODE_OUTSIDE:
                begin
                    if (at_boundary && !sensor_level && (rev_count_inc == 2'(REVS_PER_CAL)))
                    begin
                        rev_count_next = rev_count_inc;
                        coil_next      = '0;
                        rev_steps_next = total_q_reg;
                        mid_next       = inside_q_reg;
                        cal_next       = 1'b1;
                        step_next      = '0;
                        mode_next      = MODE_CENTER;
                    end
                    else
                    begin
                        coil_next      = coil_step;
                        phase_next     = phase_step;
                        total_next     = tot_cnt_inc;
                        total_rem_next = tot_rem_inc;
                        total_q_next   = tot_q_inc;
                        if (at_boundary && !sensor_level)
                        begin
                            rev_count_next  = rev_count_inc;
                            mode_next       = MODE_INSIDE;
                            inside_next     = ins_cnt_inc;
                            inside_rem_next = ins_rem_inc;
                            inside_q_next   = ins_q_inc;
                        end
                    end
                end
                MODE_CENTER:
                begin
                    coil_next  = coil_step;
                    phase_next = phase_step;
                    step_next  = step_inc;
                    if ((phase_step == '0) && (step_inc > STEP_W'(center_limit)))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_RUN:
                begin
                    if (step_reg == '0)
                    begin
                        coil_next = '0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        coil_next  = coil_step;
                        phase_next = phase_step;
                        step_next  = step_reg - STEP_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (mode_reg == MODE_IDLE)
        begin
            if (kind == KIND_CAL)
            begin
                mode_next        = MODE_SEEK;
                phase_next       = '0;
                last_sensor_next = 1'b0;
                rev_count_next   = '0;
                inside_next      = '0;
                inside_rem_next  = '0;
                inside_q_next    = '0;
                total_next       = '0;
                total_rem_next   = '0;
                total_q_next     = '0;
            end
            else if ((kind == KIND_RUN) && cal_reg)
            begin
                step_next  = run_steps;
                phase_next = '0;
                mode_next  = MODE_RUN;
            end
        end
    end

    assign res.coils          = coil_next;
    assign res.busy_res       = (mode_next != MODE_IDLE);
    assign res.calibrated     = cal_next;
    assign res.rev_half_steps = rev_steps_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= PHASE_TABLE_RESET;
        end
        else if (cfg_we)
        begin
            table_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            phase_reg       <= '0;
            last_sensor_reg <= 1'b1;
            rev_count_reg   <= '0;
            inside_reg      <= '0;
            inside_rem_reg  <= '0;
            inside_q_reg    <= '0;
            total_reg       <= '0;
            total_rem_reg   <= '0;
            total_q_reg     <= '0;
            rev_steps_reg   <= '0;
            mid_reg         <= '0;
            cal_reg         <= 1'b0;
            step_reg        <= '0;
            coil_reg        <= '0;
        end
        else if (acc)
        begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            last_sensor_reg <= last_sensor_next;
            rev_count_reg   <= rev_count_next;
            inside_reg      <= inside_next;
            inside_rem_reg  <= inside_rem_next;
            inside_q_reg    <= inside_q_next;
            total_reg       <= total_next;
            total_rem_reg   <= total_rem_next;
            total_q_reg     <= total_q_next;
            rev_steps_reg   <= rev_steps_next;
            mid_reg         <= mid_next;
            cal_reg         <= cal_next;
            step_reg        <= step_next;
            coil_reg        <= coil_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/sisc_out_buf.sv @@
`default_nettype none
module sisc_out_buf
    import sisc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire sisc_result_t push_data,
    output logic              can_push,
    sisc_out_if.source        out_ch
);

    sisc_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;
    sisc_result_t head;

    assign pop      = out_ch.valid && out_ch.ready;
    assign can_push = (count_reg != 2'd2);
    assign head     = entry_reg[rd_ptr_reg];

    assign out_ch.valid          = (count_reg != 2'd0);
    assign out_ch.coils          = head.coils;
    assign out_ch.busy_res       = head.busy_res;
    assign out_ch.calibrated     = head.calibrated;
    assign out_ch.rev_half_steps = head.rev_half_steps;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire
